/* design/clipped_rect_fill_engine_defines.svh */
// Assertion helpers for the checks in the top-level engine file.
`ifndef CLIPPED_RECT_FILL_ENGINE_DEFINES_SVH
`define CLIPPED_RECT_FILL_ENGINE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define CRFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define CRFE_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");

`endif

/* design/crfe_pkg.sv */
package crfe_pkg;

  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 256;

  localparam int COORD_W = 13;
  localparam int COLOR_W = 8;
  localparam int PIXEL_W = 3 * COLOR_W;

  localparam logic KIND_FILL = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Status of the rectangle walker as seen by the top level.
  typedef struct packed {
    logic write;  // a pixel is written this cycle
    logic last;   // it is the final pixel of the rectangle
  } walk_status_t;

endpackage

/* design/crfe_ram.sv */
module crfe_ram #(
  parameter int WIDTH = crfe_pkg::PIXEL_W,
  parameter int DEPTH = crfe_pkg::FRAME_WIDTH_DEF * crfe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/crfe_rect_walker.sv */
module crfe_rect_walker #(
  parameter int FRAME_WIDTH  = crfe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = crfe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  start,
  input  logic signed [crfe_pkg::COORD_W-1:0]                   x_first,
  input  logic signed [crfe_pkg::COORD_W-1:0]                   y_first,
  input  logic signed [crfe_pkg::COORD_W-1:0]                   x_second,
  input  logic signed [crfe_pkg::COORD_W-1:0]                   y_second,
  output crfe_pkg::walk_status_t                                status,
  output logic [((FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1)-1:0]   x,
  output logic [((FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1)-1:0] y
);

  localparam int CW = crfe_pkg::COORD_W;
  localparam int XW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam logic signed [CW-1:0] XMAX = CW'(FRAME_WIDTH - 1);
  localparam logic signed [CW-1:0] YMAX = CW'(FRAME_HEIGHT - 1);

  logic signed [CW-1:0] xlo_s, xhi_s, ylo_s, yhi_s;
  logic signed [CW-1:0] xlo_c, xhi_c, ylo_c, yhi_c;
  logic                 empty;

  logic          busy;
  logic [XW-1:0] xcnt, xlo, xhi;
  logic [YW-1:0] ycnt, yhi;
  logic          row_end;

  // Order each corner pair, then clip to the frame.
  always_comb begin
    xlo_s = (x_first < x_second) ? x_first : x_second;
    xhi_s = (x_first < x_second) ? x_second : x_first;
    ylo_s = (y_first < y_second) ? y_first : y_second;
    yhi_s = (y_first < y_second) ? y_second : y_first;
    xlo_c = (xlo_s < 0) ? '0 : xlo_s;
    ylo_c = (ylo_s < 0) ? '0 : ylo_s;
    xhi_c = (xhi_s > XMAX) ? XMAX : xhi_s;
    yhi_c = (yhi_s > YMAX) ? YMAX : yhi_s;
    empty = (xhi_s < 0) || (xlo_s > XMAX) || (yhi_s < 0) || (ylo_s > YMAX);
  end

  assign row_end      = (xcnt == xhi);
  assign status.write = busy;
  assign status.last  = busy && row_end && (ycnt == yhi);
  assign x            = xcnt;
  assign y            = ycnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= !empty;
    end else if (status.last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xcnt <= xlo_c[XW-1:0];
      xlo  <= xlo_c[XW-1:0];
      xhi  <= xhi_c[XW-1:0];
      ycnt <= ylo_c[YW-1:0];
      yhi  <= yhi_c[YW-1:0];
    end else if (busy) begin
      if (row_end) begin
        xcnt <= xlo;
        ycnt <= YW'(ycnt + 1'b1);
      end else begin
        xcnt <= XW'(xcnt + 1'b1);
      end
    end
  end

endmodule

/* design/clipped_rect_fill_engine.sv */
// Read: one word accepted per cycle unless a fill, the clearing pass or output back-pressure
// stalls input; its pixel passes the frame store's registered read port, then the output register.
// Fill: accepted, then each covered pixel is written in turn through the single write
// port; no word is accepted meanwhile. A wholly off-frame fill writes no pixel.
// Reset: a clearing pass writes black to all FRAME_WIDTH * FRAME_HEIGHT pixels (32768 at
// the default size), one per cycle, with input stalled throughout.
`include "clipped_rect_fill_engine_defines.svh"

module clipped_rect_fill_engine #(
  parameter int FRAME_WIDTH  = crfe_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = crfe_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic signed [crfe_pkg::COORD_W-1:0] x_first,
  input  logic signed [crfe_pkg::COORD_W-1:0] y_first,
  input  logic signed [crfe_pkg::COORD_W-1:0] x_second,
  input  logic signed [crfe_pkg::COORD_W-1:0] y_second,
  input  logic [crfe_pkg::COLOR_W-1:0]        red_level,
  input  logic [crfe_pkg::COLOR_W-1:0]        green_level,
  input  logic [crfe_pkg::COLOR_W-1:0]        blue_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [crfe_pkg::COLOR_W-1:0]        pixel_red,
  output logic [crfe_pkg::COLOR_W-1:0]        pixel_green,
  output logic [crfe_pkg::COLOR_W-1:0]        pixel_blue
);

  localparam int CW     = crfe_pkg::COORD_W;
  localparam int PW     = crfe_pkg::PIXEL_W;
  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int XW     = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW     = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam logic signed [CW-1:0] XMAX = CW'(FRAME_WIDTH - 1);
  localparam logic signed [CW-1:0] YMAX = CW'(FRAME_HEIGHT - 1);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  logic          state;
  logic [AW-1:0] clr_addr;

  logic in_accept, rd_acc, fill_start;

  crfe_pkg::walk_status_t walk;
  logic [XW-1:0]          walk_x;
  logic [YW-1:0]          walk_y;
  logic [PW-1:0]          fill_color;

  logic [XW-1:0] sel_x;
  logic [YW-1:0] sel_y;
  logic [AW-1:0] pix_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [PW-1:0] ram_rdata;

  logic          rd_pend, rd_zero, hold_valid, out_free, pop;
  logic [PW-1:0] land_data, hold_data, out_data;
  logic [1:0]    occ, occ_after;

  assign pop       = out_valid && !out_stall;
  assign out_free  = !out_valid || !out_stall;
  assign occ       = 2'(out_valid) + 2'(hold_valid) + 2'(rd_pend);
  assign occ_after = occ - 2'(pop);

  assign in_stall   = (state != ST_RUN) || walk.write || (occ_after >= 2'd2);
  assign in_accept  = in_valid && !in_stall;
  assign rd_acc     = in_accept && (kind == crfe_pkg::KIND_READ);
  assign fill_start = in_accept && (kind == crfe_pkg::KIND_FILL);

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= AW'(clr_addr + 1'b1);
      if (clr_addr == AW'(PIXELS - 1)) begin
        state <= ST_RUN;
      end
    end
  end

  crfe_rect_walker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_walker (
    .clk      (clk),
    .rst      (rst),
    .start    (fill_start),
    .x_first  (x_first),
    .y_first  (y_first),
    .x_second (x_second),
    .y_second (y_second),
    .status   (walk),
    .x        (walk_x),
    .y        (walk_y)
  );

  always_ff @(posedge clk) begin
    if (fill_start) begin
      fill_color <= {red_level, green_level, blue_level};
    end
  end

  // A read is never accepted while the walker writes, so one address multiplier serves both.
  assign sel_x    = walk.write ? walk_x : x_first[XW-1:0];
  assign sel_y    = walk.write ? walk_y : y_first[YW-1:0];
  assign pix_addr = AW'(AW'(sel_y) * AW'(FRAME_WIDTH) + AW'(sel_x));

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = walk.write;
      ram_waddr = pix_addr;
      ram_wdata = fill_color;
    end
  end

  crfe_ram #(
    .WIDTH (PW),
    .DEPTH (PIXELS)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_acc),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  // A read outside the frame returns black.
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      rd_zero <= (x_first < 0) || (x_first > XMAX) || (y_first < 0) || (y_first > YMAX);
    end
  end

  assign land_data = rd_zero ? '0 : ram_rdata;

  // Output register with a skid word behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      rd_pend <= rd_acc;
      if (out_free) begin
        if (hold_valid) begin
          out_valid  <= 1'b1;
          hold_valid <= rd_pend;
        end else begin
          out_valid <= rd_pend;
        end
      end else if (rd_pend) begin
        hold_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) begin
        out_data <= hold_data;
        if (rd_pend) begin
          hold_data <= land_data;
        end
      end else if (rd_pend) begin
        out_data <= land_data;
      end
    end else if (rd_pend) begin
      hold_data <= land_data;
    end
  end

  assign pixel_red   = out_data[PW-1 -: crfe_pkg::COLOR_W];
  assign pixel_green = out_data[PW-1-crfe_pkg::COLOR_W -: crfe_pkg::COLOR_W];
  assign pixel_blue  = out_data[crfe_pkg::COLOR_W-1:0];

  `CRFE_ASSERT_NEVER(a_occ_bound, clk, rst, occ == 2'd3)
  `CRFE_ASSERT_NEXT(a_read_lands, clk, rst, rd_acc, rd_pend)
  `CRFE_ASSERT_NEXT(a_walk_ends, clk, rst, walk.last, !walk.write)
  `CRFE_ASSERT_NEVER(a_no_accept_busy, clk, rst, in_accept && (walk.write || state == ST_CLEAR))

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W          = crfe_pkg::COORD_W;
  localparam int COLOR_W          = crfe_pkg::COLOR_W;
  localparam int PIXEL_W          = crfe_pkg::PIXEL_W;
  localparam int FRAME_W          = crfe_pkg::FRAME_WIDTH_DEF;
  localparam int FRAME_H          = crfe_pkg::FRAME_HEIGHT_DEF;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int DRAIN_CYCLES     = 50;
  localparam int CYCLE_LIMIT      = 3_000_000;
  localparam int REPORT_LIMIT     = 10;

  typedef struct {
    logic                      kind;
    logic signed [COORD_W-1:0] x_first;
    logic signed [COORD_W-1:0] y_first;
    logic signed [COORD_W-1:0] x_second;
    logic signed [COORD_W-1:0] y_second;
    logic [COLOR_W-1:0]        red_level;
    logic [COLOR_W-1:0]        green_level;
    logic [COLOR_W-1:0]        blue_level;
  } draw_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COLOR_W-1:0] pixel_red;
  logic [COLOR_W-1:0] pixel_green;
  logic [COLOR_W-1:0] pixel_blue;

  draw_word_t cur_word = '{default: '0};
  draw_word_t words_to_send [$];
  logic [PIXEL_W-1:0] pixels_due [$];
  logic [PIXEL_W-1:0] frame_image [FRAME_W * FRAME_H];

  logic word_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int fills_seen = 0;
  int reads_seen = 0;
  int pixels_painted = 0;

  // Bounds of the most recent random fill, so that reads can land on fresh paint.
  bit have_rect = 1'b0;
  int rect_x_lo, rect_x_hi, rect_y_lo, rect_y_hi;

  clipped_rect_fill_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (cur_word.kind),
    .x_first     (cur_word.x_first),
    .y_first     (cur_word.y_first),
    .x_second    (cur_word.x_second),
    .y_second    (cur_word.y_second),
    .red_level   (cur_word.red_level),
    .green_level (cur_word.green_level),
    .blue_level  (cur_word.blue_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic draw_word_t make_word(logic k, int xf, int yf, int xs, int ys,
                                           int r, int g, int b);
    draw_word_t w;
    w.kind        = k;
    w.x_first     = COORD_W'(xf);
    w.y_first     = COORD_W'(yf);
    w.x_second    = COORD_W'(xs);
    w.y_second    = COORD_W'(ys);
    w.red_level   = COLOR_W'(r);
    w.green_level = COLOR_W'(g);
    w.blue_level  = COLOR_W'(b);
    return w;
  endfunction

  function automatic draw_word_t random_word();
    draw_word_t w;
    int pick, side, span, xa, xb, ya, yb;
    w = make_word(crfe_pkg::KIND_FILL, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      w.kind = crfe_pkg::KIND_READ;
      if (pick < 35 && have_rect) begin
        w.x_first = COORD_W'(rect_x_lo + $urandom_range(rect_x_hi - rect_x_lo));
        w.y_first = COORD_W'(rect_y_lo + $urandom_range(rect_y_hi - rect_y_lo));
      end else if (pick < 48) begin
        w.x_first = COORD_W'($urandom_range(FRAME_W - 1));
        w.y_first = COORD_W'($urandom_range(FRAME_H - 1));
      end
    end else if (pick < 85) begin
      // Mostly small rectangles near the frame, some large ones now and then.
      span = (pick < 83) ? 9 : 63;
      xa = $urandom_range(FRAME_W + 15) - 8;
      ya = $urandom_range(FRAME_H + 15) - 8;
      xb = xa + $urandom_range(span);
      yb = ya + $urandom_range(span);
      have_rect = 1'b1;
      rect_x_lo = xa;
      rect_x_hi = xb;
      rect_y_lo = ya;
      rect_y_hi = yb;
      if ($urandom_range(1)) begin
        w.x_first  = COORD_W'(xb);
        w.x_second = COORD_W'(xa);
      end else begin
        w.x_first  = COORD_W'(xa);
        w.x_second = COORD_W'(xb);
      end
      if ($urandom_range(1)) begin
        w.y_first  = COORD_W'(yb);
        w.y_second = COORD_W'(ya);
      end else begin
        w.y_first  = COORD_W'(ya);
        w.y_second = COORD_W'(yb);
      end
    end else begin
      // Wide random corners pushed wholly off one side of the frame.
      side = $urandom_range(3);
      case (side)
        0: begin
          w.x_first[COORD_W-1]  = 1'b1;
          w.x_second[COORD_W-1] = 1'b1;
        end
        1: begin
          w.x_first  = COORD_W'(FRAME_W + $urandom_range(4095 - FRAME_W));
          w.x_second = COORD_W'(FRAME_W + $urandom_range(4095 - FRAME_W));
        end
        2: begin
          w.y_first[COORD_W-1]  = 1'b1;
          w.y_second[COORD_W-1] = 1'b1;
        end
        default: begin
          w.y_first  = COORD_W'(FRAME_H + $urandom_range(4095 - FRAME_H));
          w.y_second = COORD_W'(FRAME_H + $urandom_range(4095 - FRAME_H));
        end
      endcase
    end
    return w;
  endfunction

  // Paints the frame for a fill, or queues the pixel that a read must return.
  function automatic void paint_and_sample(draw_word_t w);
    int xa, xb, ya, yb, x_lo, x_hi, y_lo, y_hi;
    logic [PIXEL_W-1:0] colour;
    xa = w.x_first;
    ya = w.y_first;
    xb = w.x_second;
    yb = w.y_second;
    if (w.kind == crfe_pkg::KIND_READ) begin
      colour = '0;
      if (xa >= 0 && xa < FRAME_W && ya >= 0 && ya < FRAME_H)
        colour = frame_image[ya * FRAME_W + xa];
      pixels_due.push_back(colour);
      reads_seen++;
    end else begin
      colour = {w.red_level, w.green_level, w.blue_level};
      x_lo = (xa < xb) ? xa : xb;
      x_hi = (xa < xb) ? xb : xa;
      y_lo = (ya < yb) ? ya : yb;
      y_hi = (ya < yb) ? yb : ya;
      if (x_lo < 0) x_lo = 0;
      if (y_lo < 0) y_lo = 0;
      if (x_hi > FRAME_W - 1) x_hi = FRAME_W - 1;
      if (y_hi > FRAME_H - 1) y_hi = FRAME_H - 1;
      for (int y = y_lo; y <= y_hi; y++) begin
        for (int x = x_lo; x <= x_hi; x++) begin
          frame_image[y * FRAME_W + x] = colour;
          pixels_painted++;
        end
      end
      fills_seen++;
    end
  endfunction

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_word <= words_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    logic [PIXEL_W-1:0] want;
    word_taken <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall)
      paint_and_sample(cur_word);
    if (!rst && out_valid == 1'b1 && !out_stall) begin
      if (pixels_due.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("Unexpected pixel %02h %02h %02h with nothing outstanding",
                   pixel_red, pixel_green, pixel_blue);
        mismatch_count++;
      end else begin
        want = pixels_due.pop_front();
        if (pixel_red !== want[23:16] || pixel_green !== want[15:8]
            || pixel_blue !== want[7:0]) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("Pixel mismatch: expected %02h %02h %02h, got %02h %02h %02h",
                     want[23:16], want[15:8], want[7:0],
                     pixel_red, pixel_green, pixel_blue);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit");
    $display("clipped_rect_fill_engine: mismatch");
    $finish;
  end

  initial begin
    int send_pct [4];
    int stall_pct [4];
    send_pct  = '{0, 86, 0, 32};
    stall_pct = '{0, 0, 86, 32};
    foreach (frame_image[i]) frame_image[i] = '0;

    // Corner reads of the cleared frame, then a fill spanning the whole coordinate range.
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 0, 0, 4095, -4096, 255, 0, 255));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 127, 255, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_FILL, -4096, -4096, 4095, 4095,
                                      255, 255, 255));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 127, 255, 0, 0, 0, 0, 0));
    // Reads just outside the frame and at the far coordinate extremes return black.
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, -1, 0, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 128, 5, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 4095, -4096, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 5, 256, 0, 0, 0, 0, 0));
    // Corners given in reverse order on both axes.
    words_to_send.push_back(make_word(crfe_pkg::KIND_FILL, 10, 20, 3, 5,
                                      8'h12, 8'h34, 8'h56));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 3, 5, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 10, 20, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 11, 20, 0, 0, 0, 0, 0));
    // Partly off the frame: only the inside pixels change.
    words_to_send.push_back(make_word(crfe_pkg::KIND_FILL, -5, 250, 2, 300,
                                      8'hA5, 8'h5A, 8'h0F));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 0, 255, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 2, 250, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 3, 250, 0, 0, 0, 0, 0));
    // Wholly off the frame on each side: nothing changes. Then a single-pixel fill at the far corner.
    words_to_send.push_back(make_word(crfe_pkg::KIND_FILL, 128, 0, 4095, 255, 1, 2, 3));
    words_to_send.push_back(make_word(crfe_pkg::KIND_FILL, -4096, -10, -1, -1, 4, 5, 6));
    words_to_send.push_back(make_word(crfe_pkg::KIND_FILL, 0, 256, 127, 4095, 7, 8, 9));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 127, 0, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_FILL, 127, 255, 127, 255, 0, 255, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 127, 255, 0, 0, 0, 0, 0));
    words_to_send.push_back(make_word(crfe_pkg::KIND_READ, 126, 255, 0, 0, 0, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (RANDOM_PER_PHASE) words_to_send.push_back(random_word());
      while (words_to_send.size() != 0 || in_valid || pixels_due.size() != 0)
        @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d fills covering %0d pixels and %0d reads,", fills_seen,
             pixels_painted, reads_seen);
    $display("under free-running, sender-idle, receiver-stall and mixed pacing.");
    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("clipped_rect_fill_engine: match");
    end else begin
      $display("clipped_rect_fill_engine: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/crfe_pkg.sv
design/crfe_ram.sv
design/crfe_rect_walker.sv
design/clipped_rect_fill_engine.sv
verif/tb_top.sv
